[design/ctbe_pkg.sv]
// Shared types and constants for the Chebyshev tensor basis evaluator.
package ctbe_pkg;

	localparam int Q_FRAC = 28;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] Q_HALF = 64'sh0000_0000_0800_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_BASIS_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SPAN_Y = 2'd2;

	localparam logic KIND_MONOMIAL = 1'b0;
	localparam logic KIND_CHEBYSHEV = 1'b1;

	typedef struct packed {
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [7:0]         basis_index;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] basis_value;
		logic               overflow;
	} result_t;

endpackage

[design/chebyshev_tensor_basis_eval.sv]
// Tensor-product Chebyshev/monomial basis evaluator around one shared Q3.28 multiplier.
// After accept: index split, Chebyshev-only scaling of x then y, recurrence per axis, final multiply, done strobe;
//   with i = index mod GRID_SIZE, j = index div GRID_SIZE: monomial i + j steps, Chebyshev max(i-1,0) + max(j-1,0).
// Every recurrence step is a multiply, then a round/saturate writeback that forms 2*m - prev in Chebyshev mode.
// A new item is taken in the cycle the done strobe is high; the receiver cannot stall.
// Reset clears the sequencer and loads basis_kind = Chebyshev, inv_span_x = inv_span_y = 1.0.
module chebyshev_tensor_basis_eval #(
	parameter int GRID_SIZE = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  ctbe_pkg::in_item_t               item,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ctbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	output logic                             done,
	output ctbe_pkg::result_t                result
);

	localparam int I_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
	localparam int J_MAX = 255 / GRID_SIZE;
	localparam int J_W = (J_MAX > 0) ? $clog2(J_MAX + 1) : 1;
	localparam int CNT_W = (I_W > J_W) ? I_W : J_W;
	localparam int RECIP = 65536 / GRID_SIZE;
	localparam logic [24:0] RECIP_V = 25'(RECIP);
	localparam logic [7:0] N_V = 8'(GRID_SIZE);

	typedef enum logic [9:0] {
		S_IDLE      = 10'b00_0000_0001,
		S_SPLIT     = 10'b00_0000_0010,
		S_SCALE_MUL = 10'b00_0000_0100,
		S_SCALE_WB  = 10'b00_0000_1000,
		S_POLY_INIT = 10'b00_0001_0000,
		S_POLY_MUL  = 10'b00_0010_0000,
		S_POLY_WB   = 10'b00_0100_0000,
		S_POLY_DONE = 10'b00_1000_0000,
		S_FINAL_MUL = 10'b01_0000_0000,
		S_FINAL_WB  = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	logic axis_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic kind_q;
	logic signed [31:0] inv_span_x_q;
	logic signed [31:0] inv_span_y_q;

	ctbe_pkg::in_item_t item_q;
	ctbe_pkg::result_t result_q;
	logic [I_W-1:0] i_q;
	logic [J_W-1:0] j_q;
	logic signed [31:0] base_x_q;
	logic signed [31:0] base_y_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] cur_q;
	logic signed [31:0] fx_q;
	logic signed [63:0] prod_q;
	logic ovf_q;

	logic [24:0] split_prod;
	logic [7:0] q0;
	logic [7:0] r0;
	logic r_ge;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] rsum;
	logic signed [35:0] rnd;
	logic signed [31:0] m_val;
	logic m_ovf;
	logic signed [33:0] diff;
	logic signed [31:0] nxt_val;
	logic d_ovf;
	logic [CNT_W-1:0] k_sel;
	logic [CNT_W-1:0] iters;
	logic signed [31:0] base_sel;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;

	// Split flat index by reciprocal multiply with one correction step.
	always_comb begin
		split_prod = 25'(item_q.basis_index) * RECIP_V;
		q0 = split_prod[23:16];
		r0 = item_q.basis_index - q0 * N_V;
		r_ge = (r0 >= N_V);
	end

	always_comb begin
		k_sel = axis_q ? CNT_W'(j_q) : CNT_W'(i_q);
		base_sel = axis_q ? base_y_q : base_x_q;
		if (kind_q == ctbe_pkg::KIND_CHEBYSHEV) begin
			iters = (k_sel == '0) ? '0 : k_sel - CNT_W'(1);
		end else begin
			iters = k_sel;
		end
	end

	always_comb begin
		case (state_q)
			S_SCALE_MUL: begin
				mul_a = axis_q ? item_q.coord_y : item_q.coord_x;
				mul_b = axis_q ? inv_span_y_q : inv_span_x_q;
			end
			S_POLY_MUL: begin
				mul_a = base_sel;
				mul_b = cur_q;
			end
			default: begin
				mul_a = fx_q;
				mul_b = cur_q;
			end
		endcase
	end

	// Round to nearest (ties up), saturate, then form 2*m - prev.
	always_comb begin
		rsum = prod_q + ctbe_pkg::Q_HALF;
		rnd = rsum[63:28];
		if ((rnd[35:31] == 5'b00000) || (rnd[35:31] == 5'b11111)) begin
			m_val = rnd[31:0];
			m_ovf = 1'b0;
		end else begin
			m_val = rnd[35] ? ctbe_pkg::S32_MIN : ctbe_pkg::S32_MAX;
			m_ovf = 1'b1;
		end
		diff = {m_val[31], m_val, 1'b0} - {{2{prev_q[31]}}, prev_q};
		if ((diff[33:31] == 3'b000) || (diff[33:31] == 3'b111)) begin
			nxt_val = diff[31:0];
			d_ovf = 1'b0;
		end else begin
			nxt_val = diff[33] ? ctbe_pkg::S32_MIN : ctbe_pkg::S32_MAX;
			d_ovf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			kind_q <= ctbe_pkg::KIND_CHEBYSHEV;
			inv_span_x_q <= ctbe_pkg::Q_ONE;
			inv_span_y_q <= ctbe_pkg::Q_ONE;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctbe_pkg::CFG_BASIS_KIND: kind_q <= cfg_data[0];
					ctbe_pkg::CFG_INV_SPAN_X: inv_span_x_q <= cfg_data;
					ctbe_pkg::CFG_INV_SPAN_Y: inv_span_y_q <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					axis_q <= 1'b0;
					state_q <= (kind_q == ctbe_pkg::KIND_CHEBYSHEV) ? S_SCALE_MUL : S_POLY_INIT;
				end
				S_SCALE_MUL: state_q <= S_SCALE_WB;
				S_SCALE_WB: begin
					axis_q <= ~axis_q;
					state_q <= axis_q ? S_POLY_INIT : S_SCALE_MUL;
				end
				S_POLY_INIT: begin
					cnt_q <= iters;
					state_q <= (iters == '0) ? S_POLY_DONE : S_POLY_MUL;
				end
				S_POLY_MUL: state_q <= S_POLY_WB;
				S_POLY_WB: begin
					cnt_q <= cnt_q - CNT_W'(1);
					state_q <= (cnt_q == CNT_W'(1)) ? S_POLY_DONE : S_POLY_MUL;
				end
				S_POLY_DONE: begin
					axis_q <= 1'b1;
					state_q <= axis_q ? S_FINAL_MUL : S_POLY_INIT;
				end
				S_FINAL_MUL: state_q <= S_FINAL_WB;
				S_FINAL_WB: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			S_SPLIT: begin
				i_q <= I_W'(r_ge ? r0 - N_V : r0);
				j_q <= J_W'(r_ge ? q0 + 8'd1 : q0);
				base_x_q <= item_q.coord_x;
				base_y_q <= item_q.coord_y;
				ovf_q <= 1'b0;
			end
			S_SCALE_WB: begin
				if (axis_q) begin
					base_y_q <= m_val;
				end else begin
					base_x_q <= m_val;
				end
				ovf_q <= ovf_q | m_ovf;
			end
			S_POLY_INIT: begin
				prev_q <= ctbe_pkg::Q_ONE;
				if ((kind_q == ctbe_pkg::KIND_CHEBYSHEV) && (k_sel != '0)) begin
					cur_q <= base_sel;
				end else begin
					cur_q <= ctbe_pkg::Q_ONE;
				end
			end
			S_POLY_WB: begin
				if (kind_q == ctbe_pkg::KIND_CHEBYSHEV) begin
					prev_q <= cur_q;
					cur_q <= nxt_val;
					ovf_q <= ovf_q | m_ovf | d_ovf;
				end else begin
					cur_q <= m_val;
					ovf_q <= ovf_q | m_ovf;
				end
			end
			S_POLY_DONE: begin
				if (!axis_q) begin
					fx_q <= cur_q;
				end
			end
			S_FINAL_WB: begin
				result_q.basis_value <= m_val;
				result_q.overflow <= ovf_q | m_ovf;
			end
			default: begin
			end
		endcase
	end

	a_start_split: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_SPLIT))
		else $error("accepted item did not enter split");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !$past(done_q))
		else $error("done strobe longer than one cycle");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == S_FINAL_WB))
		else $error("done without final writeback");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POLY_WB) |-> (cnt_q != '0))
		else $error("recurrence step with zero count");

endmodule

[tb/sv/ctbe_basis_checker.sv]
`timescale 1ns / 1ps
// Checker for the Chebyshev tensor basis evaluator: predicts each basis value and compares results.
module ctbe_basis_checker #(
	parameter int GRID_SIZE = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  ctbe_pkg::in_item_t             item,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ctbe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           done,
	input  ctbe_pkg::result_t              result,
	output int                             fail_count,
	output int                             pending,
	output int                             sat_items
);

	logic                  kind_q;
	logic signed [31:0]    span_x_q;
	logic signed [31:0]    span_y_q;
	ctbe_pkg::result_t     expected_values[$];
	ctbe_pkg::result_t     want;

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v, inout bit sat);
		if (v > ctbe_pkg::S32_MAX) begin
			sat = 1'b1;
			return ctbe_pkg::S32_MAX;
		end
		if (v < ctbe_pkg::S32_MIN) begin
			sat = 1'b1;
			return ctbe_pkg::S32_MIN;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] mul_q28(input logic signed [31:0] a,
			input logic signed [31:0] b, inout bit sat);
		logic signed [63:0] prod;
		prod = 64'(a) * 64'(b);
		return clamp32((prod + ctbe_pkg::Q_HALF) >>> ctbe_pkg::Q_FRAC, sat);
	endfunction

	function automatic logic signed [31:0] cheb_term(input logic signed [31:0] u,
			input int unsigned k, inout bit sat);
		logic signed [31:0] prev;
		logic signed [31:0] cur;
		logic signed [31:0] nxt;
		logic signed [31:0] prod;
		logic signed [63:0] twice;
		if (k == 0)
			return ctbe_pkg::Q_ONE;
		prev = ctbe_pkg::Q_ONE;
		cur = u;
		for (int unsigned n = 2; n <= k; n++) begin
			prod = mul_q28(u, cur, sat);
			twice = 64'(prod);
			twice = (twice <<< 1) - 64'(prev);
			nxt = clamp32(twice, sat);
			prev = cur;
			cur = nxt;
		end
		return cur;
	endfunction

	function automatic logic signed [31:0] power_term(input logic signed [31:0] x,
			input int unsigned k, inout bit sat);
		logic signed [31:0] acc;
		acc = ctbe_pkg::Q_ONE;
		for (int unsigned n = 0; n < k; n++)
			acc = mul_q28(acc, x, sat);
		return acc;
	endfunction

	function automatic ctbe_pkg::result_t predict_basis(input ctbe_pkg::in_item_t it,
			input logic kind, input logic signed [31:0] sx, input logic signed [31:0] sy);
		bit                 sat;
		int unsigned        i;
		int unsigned        j;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		ctbe_pkg::result_t  r;
		sat = 1'b0;
		i = it.basis_index % GRID_SIZE;
		j = it.basis_index / GRID_SIZE;
		if (kind == ctbe_pkg::KIND_CHEBYSHEV) begin
			fx = mul_q28(it.coord_x, sx, sat);
			fy = mul_q28(it.coord_y, sy, sat);
			fx = cheb_term(fx, i, sat);
			fy = cheb_term(fy, j, sat);
		end else begin
			fx = power_term(it.coord_x, i, sat);
			fy = power_term(it.coord_y, j, sat);
		end
		r.basis_value = mul_q28(fx, fy, sat);
		r.overflow = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q = ctbe_pkg::KIND_CHEBYSHEV;
			span_x_q = ctbe_pkg::Q_ONE;
			span_y_q = ctbe_pkg::Q_ONE;
			expected_values.delete();
			fail_count = 0;
			sat_items = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_values.size() == 0) begin
					$error("result with no item outstanding: basis_value %0d overflow %0b",
						result.basis_value, result.overflow);
					fail_count++;
				end else begin
					want = expected_values.pop_front();
					if (result.basis_value !== want.basis_value) begin
						$error("basis_value: expected %0d, got %0d",
							want.basis_value, result.basis_value);
						fail_count++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				want = predict_basis(item, kind_q, span_x_q, span_y_q);
				if (want.overflow)
					sat_items++;
				expected_values.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ctbe_pkg::CFG_BASIS_KIND: kind_q = cfg_data[0];
					ctbe_pkg::CFG_INV_SPAN_X: span_x_q = cfg_data;
					ctbe_pkg::CFG_INV_SPAN_Y: span_y_q = cfg_data;
					default: ;
				endcase
			end
			pending = expected_values.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the Chebyshev tensor basis evaluator: clock, reset, stimulus and verdict.
module tb_top;

	localparam int GRID = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 119;
	localparam int TAIL_CYCLES = 80;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	ctbe_pkg::in_item_t             item;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [ctbe_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0]                    cfg_data;
	logic                           done;
	ctbe_pkg::result_t              result;

	int fail_count;
	int pending;
	int sat_items;
	int cycle_cnt = 0;
	int items_sent = 0;
	int settings_used = 0;
	int gap_mode = 0;

	logic signed [31:0] span_table [8];

	always #1 clk = ~clk;

	chebyshev_tensor_basis_eval #(
		.GRID_SIZE(GRID)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.result(result)
	);

	ctbe_basis_checker #(
		.GRID_SIZE(GRID)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.result(result),
		.fail_count(fail_count),
		.pending(pending),
		.sat_items(sat_items)
	);

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAIL chebyshev_tensor_basis_eval");
			$finish;
		end
	end

	task automatic send_item(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [7:0] idx);
		@(negedge clk);
		start <= 1'b1;
		item <= '{coord_x: x, coord_y: y, basis_index: idx};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic idle(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	// hold until every outstanding item has returned
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [ctbe_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_setting(input logic kind, input logic signed [31:0] sx,
			input logic signed [31:0] sy);
		logic [31:0] kind_word;
		kind_word = $urandom();
		kind_word[0] = kind;
		write_reg(ctbe_pkg::CFG_BASIS_KIND, kind_word);
		write_reg(ctbe_pkg::CFG_INV_SPAN_X, sx);
		write_reg(ctbe_pkg::CFG_INV_SPAN_Y, sy);
		settings_used++;
	endtask

	function automatic int pick_gap();
		int r;
		if (gap_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $signed($urandom_range(0, 32'h2000_0000)) - ctbe_pkg::Q_ONE;
		if (r < 75)
			return $signed($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
		if (r < 90)
			return $urandom();
		case ($urandom_range(0, 6))
			0: return 32'sh0;
			1: return ctbe_pkg::Q_ONE;
			2: return -ctbe_pkg::Q_ONE;
			3: return ctbe_pkg::S32_MAX;
			4: return ctbe_pkg::S32_MIN;
			5: return 32'sh1;
			default: return -32'sh1;
		endcase
	endfunction

	function automatic logic [7:0] rand_index();
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, 4) * GRID + $urandom_range(0, 4));
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = ctbe_pkg::CFG_BASIS_KIND;
		cfg_data = '0;
		span_table[0] = ctbe_pkg::Q_ONE;
		span_table[1] = 32'sh0800_0000;
		span_table[2] = 32'sh2000_0000;
		span_table[3] = -ctbe_pkg::Q_ONE;
		span_table[4] = ctbe_pkg::S32_MAX;
		span_table[5] = ctbe_pkg::S32_MIN;
		span_table[6] = 32'sh0;
		span_table[7] = $urandom();
		repeat (8)
			@(negedge clk);
		arst_n <= 1'b1;

		// Chebyshev with the reset spans
		send_item(32'sh0, 32'sh0, 8'h00);
		send_item(32'sh0800_0000, 32'sh0, 8'h01);
		send_item(32'sh0800_0000, 32'sh0800_0000, 8'h22);
		send_item(ctbe_pkg::Q_ONE, -ctbe_pkg::Q_ONE, 8'hFF);
		send_item(-ctbe_pkg::Q_ONE, ctbe_pkg::Q_ONE, 8'hEE);
		send_item(ctbe_pkg::S32_MAX, ctbe_pkg::S32_MAX, 8'hFF);
		send_item(ctbe_pkg::S32_MIN, ctbe_pkg::S32_MIN, 8'h00);
		send_item(ctbe_pkg::S32_MIN, ctbe_pkg::S32_MAX, 8'h11);
		send_item(32'sh1, -32'sh1, 8'h0F);
		send_item(32'sh0FFF_FFFF, 32'sh8000_0001, 8'h1F);
		send_item(32'sh2000_0000, 32'sh0, 8'h03);
		drain();
		write_setting(ctbe_pkg::KIND_CHEBYSHEV, ctbe_pkg::S32_MIN, ctbe_pkg::S32_MAX);
		send_item(ctbe_pkg::S32_MIN, ctbe_pkg::S32_MIN, 8'h00);
		send_item(ctbe_pkg::Q_ONE, -ctbe_pkg::Q_ONE, 8'h12);
		drain();
		write_setting(ctbe_pkg::KIND_MONOMIAL, ctbe_pkg::Q_ONE, ctbe_pkg::Q_ONE);
		send_item(32'sh0, 32'sh0, 8'h00);
		send_item(32'sh0, ctbe_pkg::Q_ONE, 8'h03);
		send_item(32'sh2000_0000, ctbe_pkg::Q_ONE, 8'h0F);
		send_item(ctbe_pkg::S32_MIN, ctbe_pkg::S32_MAX, 8'h11);
		send_item(-ctbe_pkg::Q_ONE, 32'sh0800_0000, 8'hFF);
		send_item(ctbe_pkg::S32_MAX, ctbe_pkg::S32_MIN, 8'h00);
		send_item(ctbe_pkg::Q_ONE + 32'sh1, -32'sh1, 8'h21);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			write_setting((p % 2 == 1) ? ctbe_pkg::KIND_CHEBYSHEV : ctbe_pkg::KIND_MONOMIAL,
				span_table[p], span_table[(p + 3) % 8]);
			gap_mode = (p == 2) ? 0 : 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 59) == 0)
					drain();
				idle(pick_gap());
				send_item(rand_coord(), rand_coord(), rand_index());
			end
		end

		drain();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		$display("covered %0d items over %0d register settings, both basis kinds",
			items_sent, settings_used + 1);
		$display("%0d items expected to saturate, %0d items still outstanding",
			sat_items, pending);
		if (fail_count == 0 && pending == 0)
			$display("PASS chebyshev_tensor_basis_eval");
		else
			$display("FAIL chebyshev_tensor_basis_eval");
		$finish;
	end

endmodule

[sim.f]
design/ctbe_pkg.sv
design/chebyshev_tensor_basis_eval.sv
tb/sv/ctbe_basis_checker.sv
tb/sv/tb_top.sv
